// ===== sv/assert_macros.svh =====
// ============================================================================
// assert_macros.svh
// Assertion shorthands shared by the flood-fill block.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check; held off while reset is asserted.
`define MWFF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define MWFF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/mwff_pkg.sv =====
// ============================================================================
// mwff_pkg
// Shared constants, types and helpers of the maze wall map / flood fill.
// ============================================================================
package mwff_pkg;

    localparam int MAZE_DIM   = 16;
    localparam int CELLS      = MAZE_DIM * MAZE_DIM;
    localparam int COORD_W    = $clog2(MAZE_DIM);
    localparam int CELL_W     = $clog2(CELLS);
    localparam int IN_COORD_W = 4;
    localparam int REQ_W      = 2;
    localparam int WALL_W     = 4;
    localparam int DIST_W     = 8;
    localparam int SWEEP_W    = 8;
    localparam int GOAL_LO    = MAZE_DIM / 2 - 1;
    localparam int GOAL_HI    = MAZE_DIM / 2;

    localparam logic [DIST_W-1:0]  DIST_MAX  = '1;
    localparam logic [SWEEP_W-1:0] SWEEP_MAX = '1;
    localparam logic [COORD_W-1:0] COORD_LAST = COORD_W'(MAZE_DIM - 1);

    localparam logic [REQ_W-1:0] REQ_ADD_WALLS = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RECOMPUTE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ      = 2'd2;

    localparam logic [WALL_W-1:0] WBIT_N = 4'd1;
    localparam logic [WALL_W-1:0] WBIT_E = 4'd2;
    localparam logic [WALL_W-1:0] WBIT_S = 4'd4;
    localparam logic [WALL_W-1:0] WBIT_W = 4'd8;

    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_E = 2'd1;
    localparam logic [1:0] DIR_S = 2'd2;
    localparam logic [1:0] DIR_W = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_AW_CELL_RD,
        S_AW_CELL_WR,
        S_AW_NB_CHK,
        S_AW_NB_WR,
        S_RC_INIT,
        S_RC_CELL_RD,
        S_RC_LATCH,
        S_RC_NB_CHK,
        S_RC_NB_WR,
        S_RC_SWEEP_END,
        S_FIN_RD,
        S_OUT
    } t_state;

    typedef enum logic {
        WW_ZERO,
        WW_OR
    } t_wall_sel;

    typedef enum logic [1:0] {
        DW_MANH,
        DW_INIT,
        DW_CAND
    } t_dist_sel;

    typedef struct packed {
        logic      idle;
        logic      load_req;
        logic      base_req;
        logic      use_nb;
        logic      wall_we;
        t_wall_sel wall_sel;
        logic      dist_we;
        t_dist_sel dist_sel;
        logic      scan_clr;
        logic      scan_inc;
        logic      dir_clr;
        logic      dir_inc;
        logic      latch_cell;
        logic      changed_clr;
        logic      sweep_clr;
        logic      sweep_inc;
        logic      load_out;
    } t_cmd;

    typedef struct packed {
        logic [REQ_W-1:0] in_type;
        logic             in_oob;
        logic             nb_ok;
        logic             cell_live;
        logic             better;
        logic             scan_last;
        logic             dir_last;
        logic             changed;
        logic             out_free;
    } t_sts;

    function automatic logic [CELL_W-1:0] cell_index(
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y
    );
        return CELL_W'(CELL_W'(x) * CELL_W'(MAZE_DIM) + CELL_W'(y));
    endfunction

    function automatic logic [DIST_W-1:0] axis_gap(input logic [COORD_W-1:0] v);
        logic [DIST_W-1:0] g;
        if (v < COORD_W'(GOAL_LO)) begin
            g = DIST_W'(COORD_W'(GOAL_LO) - v);
        end else if (v > COORD_W'(GOAL_HI)) begin
            g = DIST_W'(v - COORD_W'(GOAL_HI));
        end else begin
            g = '0;
        end
        return g;
    endfunction

    function automatic logic is_goal(
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y
    );
        return (x == COORD_W'(GOAL_LO) || x == COORD_W'(GOAL_HI)) &&
               (y == COORD_W'(GOAL_LO) || y == COORD_W'(GOAL_HI));
    endfunction

    // wall bit that the neighbor in direction dir gets
    function automatic logic [WALL_W-1:0] opposite_wall(input logic [1:0] dir);
        logic [WALL_W-1:0] m;
        case (dir)
            DIR_N:   m = WBIT_S;
            DIR_E:   m = WBIT_W;
            DIR_S:   m = WBIT_N;
            default: m = WBIT_E;
        endcase
        return m;
    endfunction

endpackage

// ===== sv/maze_wall_map_flood_fill.sv =====
// ============================================================================
// maze_wall_map_flood_fill
// Micromouse wall map and flood-fill distance map for a square maze.
// ============================================================================
// After reset the block runs a clearing pass over all 256 cells (one cell per
// cycle) that zeroes the wall map and loads Manhattan distances; input stalls
// meanwhile. Items are handled one at a time, all map traffic going through
// one read and one write port per map. A read accepts the item, reads both
// maps and loads the output word. An add-walls item reads and updates the
// cell, then checks all four directions, updating the wall of each existing
// neighbor behind a set wall bit. A recompute runs a goal initialization
// pass, then sweeps over all cells, relaxing the open neighbors of each
// reachable cell, repeated until a sweep changes nothing.
// ============================================================================
module maze_wall_map_flood_fill (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [mwff_pkg::REQ_W-1:0]          i_req_type,
    input  logic [mwff_pkg::IN_COORD_W-1:0]     i_cell_x,
    input  logic [mwff_pkg::IN_COORD_W-1:0]     i_cell_y,
    input  logic [mwff_pkg::WALL_W-1:0]         i_wall_bits,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [mwff_pkg::DIST_W-1:0]         o_cell_distance,
    output logic [mwff_pkg::WALL_W-1:0]         o_cell_walls,
    output logic [mwff_pkg::SWEEP_W-1:0]        o_sweep_count
);

    mwff_pkg::t_cmd cmd;
    mwff_pkg::t_sts sts;

    mwff_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mwff_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_req_type      (i_req_type),
        .i_cell_x        (i_cell_x),
        .i_cell_y        (i_cell_y),
        .i_wall_bits     (i_wall_bits),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_cell_distance (o_cell_distance),
        .o_cell_walls    (o_cell_walls),
        .o_sweep_count   (o_sweep_count)
    );

    assign o_in_stall = !cmd.idle;

endmodule

// ===== sv/mwff_ram.sv =====
// ============================================================================
// mwff_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module mwff_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/mwff_dp.sv =====
// ============================================================================
// mwff_dp
// Datapath: request and scan registers, neighbor addressing, both maps,
// relaxation compare and the output word register.
// ============================================================================
`include "assert_macros.svh"

module mwff_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mwff_pkg::t_cmd                      i_cmd,
    output mwff_pkg::t_sts                      o_sts,
    input  logic [mwff_pkg::REQ_W-1:0]          i_req_type,
    input  logic [mwff_pkg::IN_COORD_W-1:0]     i_cell_x,
    input  logic [mwff_pkg::IN_COORD_W-1:0]     i_cell_y,
    input  logic [mwff_pkg::WALL_W-1:0]         i_wall_bits,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [mwff_pkg::DIST_W-1:0]         o_cell_distance,
    output logic [mwff_pkg::WALL_W-1:0]         o_cell_walls,
    output logic [mwff_pkg::SWEEP_W-1:0]        o_sweep_count
);

    localparam int CW = mwff_pkg::COORD_W;

    logic [CW-1:0]                    r_x, r_y, r_sx, r_sy;
    logic [mwff_pkg::WALL_W-1:0]      r_wb, r_cw;
    logic                             r_oob;
    logic [1:0]                       r_dir;
    logic [mwff_pkg::DIST_W-1:0]      r_cd;
    logic                             r_changed;
    logic [mwff_pkg::SWEEP_W-1:0]     r_sweeps;
    logic                             r_out_valid;
    logic [mwff_pkg::DIST_W-1:0]      r_out_dist;
    logic [mwff_pkg::WALL_W-1:0]      r_out_walls;
    logic [mwff_pkg::SWEEP_W-1:0]     r_out_sweeps;

    logic [CW-1:0]                    bx, by, nx, ny, ax, ay;
    logic                             nb_exists;
    logic [mwff_pkg::CELL_W-1:0]      addr;
    logic [mwff_pkg::WALL_W-1:0]      wall_rdata, wall_wdata;
    logic [mwff_pkg::DIST_W-1:0]      dist_rdata, dist_wdata, cand;
    logic                             in_oob;

    assign in_oob = (5'(i_cell_x) >= 5'(mwff_pkg::MAZE_DIM)) ||
                    (5'(i_cell_y) >= 5'(mwff_pkg::MAZE_DIM));

    assign bx = i_cmd.base_req ? r_x : r_sx;
    assign by = i_cmd.base_req ? r_y : r_sy;

    always_comb begin
        nx = bx;
        ny = by;
        case (r_dir)
            mwff_pkg::DIR_N: begin
                ny        = by - CW'(1);
                nb_exists = by != '0;
            end
            mwff_pkg::DIR_E: begin
                nx        = bx + CW'(1);
                nb_exists = bx != mwff_pkg::COORD_LAST;
            end
            mwff_pkg::DIR_S: begin
                ny        = by + CW'(1);
                nb_exists = by != mwff_pkg::COORD_LAST;
            end
            default: begin
                nx        = bx - CW'(1);
                nb_exists = bx != '0;
            end
        endcase
    end

    assign ax   = i_cmd.use_nb ? nx : bx;
    assign ay   = i_cmd.use_nb ? ny : by;
    assign addr = mwff_pkg::cell_index(ax, ay);
    assign cand = r_cd + mwff_pkg::DIST_W'(1);

    always_comb begin
        case (i_cmd.wall_sel)
            mwff_pkg::WW_ZERO: wall_wdata = '0;
            default: wall_wdata = wall_rdata |
                                  (i_cmd.use_nb ? mwff_pkg::opposite_wall(r_dir) : r_wb);
        endcase
        case (i_cmd.dist_sel)
            mwff_pkg::DW_MANH: dist_wdata = mwff_pkg::axis_gap(r_sx) + mwff_pkg::axis_gap(r_sy);
            mwff_pkg::DW_INIT: dist_wdata = mwff_pkg::is_goal(r_sx, r_sy) ? '0
                                                                        : mwff_pkg::DIST_MAX;
            default:           dist_wdata = cand;
        endcase
    end

    mwff_ram #(.WIDTH(mwff_pkg::WALL_W), .DEPTH(mwff_pkg::CELLS)) u_wall_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wall_we),
        .i_waddr (addr),
        .i_wdata (wall_wdata),
        .i_raddr (addr),
        .o_rdata (wall_rdata)
    );

    mwff_ram #(.WIDTH(mwff_pkg::DIST_W), .DEPTH(mwff_pkg::CELLS)) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.dist_we),
        .i_waddr (addr),
        .i_wdata (dist_wdata),
        .i_raddr (addr),
        .o_rdata (dist_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_x   <= CW'(i_cell_x);
            r_y   <= CW'(i_cell_y);
            r_wb  <= i_wall_bits;
            r_oob <= in_oob;
        end
        if (i_cmd.latch_cell) begin
            r_cd <= dist_rdata;
            r_cw <= wall_rdata;
        end
        if (i_cmd.load_out) begin
            r_out_dist   <= r_oob ? mwff_pkg::DIST_MAX : dist_rdata;
            r_out_walls  <= r_oob ? '0 : wall_rdata;
            r_out_sweeps <= r_sweeps;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx        <= '0;
            r_sy        <= '0;
            r_dir       <= '0;
            r_changed   <= 1'b0;
            r_sweeps    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.scan_clr) begin
                r_sx <= '0;
                r_sy <= '0;
            end else if (i_cmd.scan_inc) begin
                if (r_sy == mwff_pkg::COORD_LAST) begin
                    r_sy <= '0;
                    r_sx <= (r_sx == mwff_pkg::COORD_LAST) ? '0 : r_sx + CW'(1);
                end else begin
                    r_sy <= r_sy + CW'(1);
                end
            end
            if (i_cmd.dir_clr) begin
                r_dir <= '0;
            end else if (i_cmd.dir_inc) begin
                r_dir <= r_dir + 2'd1;
            end
            if (i_cmd.changed_clr) begin
                r_changed <= 1'b0;
            end else if (i_cmd.dist_we && i_cmd.dist_sel == mwff_pkg::DW_CAND) begin
                r_changed <= 1'b1;
            end
            if (i_cmd.sweep_clr) begin
                r_sweeps <= '0;
            end else if (i_cmd.sweep_inc && r_sweeps != mwff_pkg::SWEEP_MAX) begin
                r_sweeps <= r_sweeps + mwff_pkg::SWEEP_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.in_type   = i_req_type;
    assign o_sts.in_oob    = in_oob;
    assign o_sts.nb_ok     = nb_exists && (i_cmd.base_req ? r_wb[r_dir] : !r_cw[r_dir]);
    assign o_sts.cell_live = r_cd != mwff_pkg::DIST_MAX;
    assign o_sts.better    = dist_rdata > cand;
    assign o_sts.scan_last = (r_sx == mwff_pkg::COORD_LAST) && (r_sy == mwff_pkg::COORD_LAST);
    assign o_sts.dir_last  = r_dir == mwff_pkg::DIR_W;
    assign o_sts.changed   = r_changed;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_cell_distance = r_out_dist;
    assign o_cell_walls    = r_out_walls;
    assign o_sweep_count   = r_out_sweeps;

    `MWFF_ASSERT(a_cand_lowers, (i_cmd.dist_we && i_cmd.dist_sel == mwff_pkg::DW_CAND) |-> (dist_rdata > cand), "relaxation write does not lower the distance")
    `MWFF_ASSERT(a_cand_live, (i_cmd.dist_we && i_cmd.dist_sel == mwff_pkg::DW_CAND) |-> (r_cd != mwff_pkg::DIST_MAX), "unreachable cell offered a distance")
    `MWFF_ASSERT(a_out_hold, (r_out_valid && i_out_stall) |=> ($stable(r_out_dist) && $stable(r_out_sweeps)), "output word changed while held")

endmodule

// ===== sv/mwff_ctrl.sv =====
// ============================================================================
// mwff_ctrl
// Controller: sequences clearing, wall updates, flood sweeps and readout.
// ============================================================================
`include "assert_macros.svh"

module mwff_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  mwff_pkg::t_sts i_sts,
    output mwff_pkg::t_cmd o_cmd
);

    mwff_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mwff_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            mwff_pkg::S_CLEAR: begin
                o_cmd.wall_we  = 1'b1;
                o_cmd.wall_sel = mwff_pkg::WW_ZERO;
                o_cmd.dist_we  = 1'b1;
                o_cmd.dist_sel = mwff_pkg::DW_MANH;
                o_cmd.scan_inc = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = mwff_pkg::S_IDLE;
                end
            end
            mwff_pkg::S_IDLE: begin
                o_cmd.idle        = 1'b1;
                o_cmd.scan_clr    = 1'b1;
                o_cmd.dir_clr     = 1'b1;
                o_cmd.sweep_clr   = 1'b1;
                o_cmd.changed_clr = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    if (i_sts.in_oob) begin
                        n_state = mwff_pkg::S_OUT;
                    end else if (i_sts.in_type == mwff_pkg::REQ_ADD_WALLS) begin
                        n_state = mwff_pkg::S_AW_CELL_RD;
                    end else if (i_sts.in_type == mwff_pkg::REQ_RECOMPUTE) begin
                        n_state = mwff_pkg::S_RC_INIT;
                    end else begin
                        n_state = mwff_pkg::S_FIN_RD;
                    end
                end
            end
            mwff_pkg::S_AW_CELL_RD: begin
                o_cmd.base_req = 1'b1;
                n_state        = mwff_pkg::S_AW_CELL_WR;
            end
            mwff_pkg::S_AW_CELL_WR: begin
                o_cmd.base_req = 1'b1;
                o_cmd.wall_we  = 1'b1;
                o_cmd.wall_sel = mwff_pkg::WW_OR;
                n_state        = mwff_pkg::S_AW_NB_CHK;
            end
            mwff_pkg::S_AW_NB_CHK: begin
                o_cmd.base_req = 1'b1;
                o_cmd.use_nb   = 1'b1;
                if (i_sts.nb_ok) begin
                    n_state = mwff_pkg::S_AW_NB_WR;
                end else begin
                    o_cmd.dir_inc = 1'b1;
                    if (i_sts.dir_last) begin
                        n_state = mwff_pkg::S_FIN_RD;
                    end
                end
            end
            mwff_pkg::S_AW_NB_WR: begin
                o_cmd.base_req = 1'b1;
                o_cmd.use_nb   = 1'b1;
                o_cmd.wall_we  = 1'b1;
                o_cmd.wall_sel = mwff_pkg::WW_OR;
                o_cmd.dir_inc  = 1'b1;
                n_state = i_sts.dir_last ? mwff_pkg::S_FIN_RD : mwff_pkg::S_AW_NB_CHK;
            end
            mwff_pkg::S_RC_INIT: begin
                o_cmd.dist_we  = 1'b1;
                o_cmd.dist_sel = mwff_pkg::DW_INIT;
                o_cmd.scan_inc = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = mwff_pkg::S_RC_CELL_RD;
                end
            end
            mwff_pkg::S_RC_CELL_RD: begin
                o_cmd.dir_clr = 1'b1;
                n_state       = mwff_pkg::S_RC_LATCH;
            end
            mwff_pkg::S_RC_LATCH: begin
                o_cmd.latch_cell = 1'b1;
                n_state          = mwff_pkg::S_RC_NB_CHK;
            end
            mwff_pkg::S_RC_NB_CHK: begin
                o_cmd.use_nb = 1'b1;
                if (i_sts.cell_live && i_sts.nb_ok) begin
                    n_state = mwff_pkg::S_RC_NB_WR;
                end else if (i_sts.cell_live && !i_sts.dir_last) begin
                    o_cmd.dir_inc = 1'b1;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                    n_state = i_sts.scan_last ? mwff_pkg::S_RC_SWEEP_END
                                              : mwff_pkg::S_RC_CELL_RD;
                end
            end
            mwff_pkg::S_RC_NB_WR: begin
                o_cmd.use_nb   = 1'b1;
                o_cmd.dist_sel = mwff_pkg::DW_CAND;
                o_cmd.dist_we  = i_sts.better;
                if (i_sts.dir_last) begin
                    o_cmd.scan_inc = 1'b1;
                    n_state = i_sts.scan_last ? mwff_pkg::S_RC_SWEEP_END
                                              : mwff_pkg::S_RC_CELL_RD;
                end else begin
                    o_cmd.dir_inc = 1'b1;
                    n_state       = mwff_pkg::S_RC_NB_CHK;
                end
            end
            mwff_pkg::S_RC_SWEEP_END: begin
                o_cmd.sweep_inc   = 1'b1;
                o_cmd.changed_clr = 1'b1;
                n_state = i_sts.changed ? mwff_pkg::S_RC_CELL_RD : mwff_pkg::S_FIN_RD;
            end
            mwff_pkg::S_FIN_RD: begin
                o_cmd.base_req = 1'b1;
                n_state        = mwff_pkg::S_OUT;
            end
            mwff_pkg::S_OUT: begin
                o_cmd.base_req = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = mwff_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mwff_pkg::S_IDLE;
            end
        endcase
    end

    `MWFF_ASSERT(a_load_free, o_cmd.load_out |-> i_sts.out_free, "output word overwritten")
    `MWFF_ASSERT(a_wr_after_chk, (r_state == mwff_pkg::S_RC_NB_WR) |-> ($past(r_state) == mwff_pkg::S_RC_NB_CHK), "neighbor write without fresh read")
    `MWFF_ASSERT(a_clear_to_idle, ($past(r_state) == mwff_pkg::S_CLEAR && r_state != mwff_pkg::S_CLEAR) |-> (r_state == mwff_pkg::S_IDLE), "clearing pass left to a busy state")

endmodule
